// ===== rtl/ls2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls2_pkg
// Shared types and constants of the 2x2 linear system solver.
// ----------------------------------------------------------------------------
package ls2_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned ProdW = 33;
  localparam int unsigned DivW  = 49;
  localparam int unsigned SolW  = 48;

  typedef enum logic [1:0] {
    STAT_UNIQUE = 2'd0,
    STAT_INFINITE = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ProdW-1:0] det;
    logic signed [ProdW-1:0] num1;
    logic signed [ProdW-1:0] num2;
    status_e                 status;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/linear_system_2x2_solver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_system_2x2_solver
// Cramer's rule solver for a 2x2 integer system, Q31.16 results.
// ----------------------------------------------------------------------------
// Accepts one system per cycle while not full and returns one result per
// system in order. On the way to the ports, two front stages form the
// determinant and numerators and classify the system, the job passes
// through the short queue, then a load stage and a 49-stage restoring
// divider yield both quotients, one bit per stage.
// A stalled pop holds the result and backs up the divider, then the queue,
// then the front.
module linear_system_2x2_solver #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic signed [15:0] coef_r1c1_i,
  input  wire logic signed [15:0] coef_r1c2_i,
  input  wire logic signed [15:0] coef_r2c1_i,
  input  wire logic signed [15:0] coef_r2c2_i,
  input  wire logic signed [15:0] rhs_first_i,
  input  wire logic signed [15:0] rhs_second_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status_o,
  output logic signed [47:0] solution_first_o,
  output logic signed [47:0] solution_second_o
);

  logic             f_valid, f_ready, q_valid, q_ready, rdy, vout;
  ls2_pkg::job_t    f_job, q_job;
  ls2_pkg::status_e st;

  ls2_front u_front (
    .clk_i, .rst_ni, .valid_i(push), .ready_o(rdy),
    .a11_i(coef_r1c1_i), .a12_i(coef_r1c2_i), .a21_i(coef_r2c1_i),
    .a22_i(coef_r2c2_i), .b1_i(rhs_first_i), .b2_i(rhs_second_i),
    .valid_o(f_valid), .ready_i(f_ready), .job_o(f_job)
  );

  ls2_queue #(.Width($bits(ls2_pkg::job_t)), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .valid_i(f_valid), .ready_o(f_ready), .data_i(f_job),
    .valid_o(q_valid), .ready_i(q_ready), .data_o(q_job)
  );

  ls2_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .ready_o(q_ready), .job_i(q_job),
    .valid_o(vout), .ready_i(pop), .status_o(st),
    .sol1_o(solution_first_o), .sol2_o(solution_second_o)
  );

  assign full     = !rdy;
  assign empty    = !vout;
  assign status_o = st;

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ls2_pkg::STAT_UNIQUE || status_o == ls2_pkg::STAT_INFINITE ||
                status_o == ls2_pkg::STAT_NONE))
    else $error("bad status");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ls2_pkg::STAT_UNIQUE) |->
      (solution_first_o == '0 && solution_second_o == '0))
    else $error("nonzero solution for singular system");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(solution_first_o) && $stable(status_o)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/ls2_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls2_front
// Forms determinant and Cramer numerators, classifies the system.
// Two stages: products, then differences and class.
// ----------------------------------------------------------------------------
module ls2_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  output logic                                  ready_o,
  input  wire logic signed [ls2_pkg::CoefW-1:0] a11_i,
  input  wire logic signed [ls2_pkg::CoefW-1:0] a12_i,
  input  wire logic signed [ls2_pkg::CoefW-1:0] a21_i,
  input  wire logic signed [ls2_pkg::CoefW-1:0] a22_i,
  input  wire logic signed [ls2_pkg::CoefW-1:0] b1_i,
  input  wire logic signed [ls2_pkg::CoefW-1:0] b2_i,
  output logic                                  valid_o,
  input  wire logic                             ready_i,
  output ls2_pkg::job_t                         job_o
);

  localparam int unsigned PW = 2 * ls2_pkg::CoefW;

  logic                 v1_q, v2_q;
  logic signed [PW-1:0] p_q [6];
  logic                 zmat_q, zrhs_q;
  ls2_pkg::job_t        job_q;
  logic                 adv2, adv1;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;
  assign valid_o = v2_q;
  assign job_o   = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      p_q[0] <= a11_i * a22_i;
      p_q[1] <= a12_i * a21_i;
      p_q[2] <= b1_i * a22_i;
      p_q[3] <= b2_i * a12_i;
      p_q[4] <= a11_i * b2_i;
      p_q[5] <= a21_i * b1_i;
      zmat_q <= (a11_i == '0) && (a12_i == '0) && (a21_i == '0) && (a22_i == '0);
      zrhs_q <= (b1_i == '0) && (b2_i == '0);
    end
  end

  logic signed [ls2_pkg::ProdW-1:0] det_c, n1_c, n2_c;
  always_comb begin
    det_c = ls2_pkg::ProdW'(p_q[0]) - ls2_pkg::ProdW'(p_q[1]);
    n1_c  = ls2_pkg::ProdW'(p_q[2]) - ls2_pkg::ProdW'(p_q[3]);
    n2_c  = ls2_pkg::ProdW'(p_q[4]) - ls2_pkg::ProdW'(p_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      job_q.det  <= det_c;
      job_q.num1 <= n1_c;
      job_q.num2 <= n2_c;
      if (det_c != '0) job_q.status <= ls2_pkg::STAT_UNIQUE;
      else if (n1_c == '0 && n2_c == '0 && !(zmat_q && !zrhs_q))
        job_q.status <= ls2_pkg::STAT_INFINITE;
      else job_q.status <= ls2_pkg::STAT_NONE;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ls2_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls2_queue
// Small register queue decoupling front and back.
// ----------------------------------------------------------------------------
module ls2_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [Width-1:0]      data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             wr, rd;

  assign ready_o = cnt_q != (AW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign wr      = valid_i && ready_o;
  assign rd      = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/ls2_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ls2_back
// Pipelined restoring divider: (num << 16) / det, truncated, saturated.
// One quotient bit per stage, both quotients in parallel lanes.
// ----------------------------------------------------------------------------
module ls2_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  ls2_pkg::job_t    job_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output ls2_pkg::status_e status_o,
  output logic signed [ls2_pkg::SolW-1:0] sol1_o,
  output logic signed [ls2_pkg::SolW-1:0] sol2_o
);

  localparam int unsigned NW = ls2_pkg::DivW;
  localparam int unsigned DW = ls2_pkg::ProdW;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NS = NW;

  typedef struct packed {
    logic [NW-1:0]    q1, q2;
    logic [RW-1:0]    r1, r2;
    logic [DW-1:0]    dmag;
    logic             neg1, neg2;
    ls2_pkg::status_e status;
  } lane_t;

  logic  v_q [NS+1];
  lane_t s_q [NS+1];
  logic  adv [NS+1];

  // stage 0 loads magnitudes
  always_comb begin
    adv[NS] = !v_q[NS] || ready_i;
    for (int i = NS - 1; i >= 0; i--) adv[i] = !v_q[i] || adv[i+1];
  end
  assign ready_o = adv[0];

  logic [DW-1:0] dmag_c, n1m, n2m;
  assign dmag_c = job_i.det[DW-1] ? DW'(-job_i.det) : DW'(job_i.det);
  assign n1m    = job_i.num1[DW-1] ? DW'(-job_i.num1) : DW'(job_i.num1);
  assign n2m    = job_i.num2[DW-1] ? DW'(-job_i.num2) : DW'(job_i.num2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) v_q[i] <= 1'b0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int i = 1; i <= NS; i++) if (adv[i]) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      s_q[0].q1     <= {n1m, 16'd0};
      s_q[0].q2     <= {n2m, 16'd0};
      s_q[0].r1     <= '0;
      s_q[0].r2     <= '0;
      s_q[0].dmag   <= dmag_c;
      s_q[0].neg1   <= job_i.num1[DW-1] ^ job_i.det[DW-1];
      s_q[0].neg2   <= job_i.num2[DW-1] ^ job_i.det[DW-1];
      s_q[0].status <= job_i.status;
    end
  end

  for (genvar g = 1; g <= NS; g++) begin : g_stage
    logic [RW-1:0] t1, t2;
    logic [RW:0]   d1, d2;
    lane_t         nx;
    always_comb begin
      nx = s_q[g-1];
      t1 = {s_q[g-1].r1[RW-2:0], s_q[g-1].q1[NW-1]};
      t2 = {s_q[g-1].r2[RW-2:0], s_q[g-1].q2[NW-1]};
      d1 = {1'b0, t1} - {2'b0, s_q[g-1].dmag};
      d2 = {1'b0, t2} - {2'b0, s_q[g-1].dmag};
      nx.r1 = d1[RW] ? t1 : d1[RW-1:0];
      nx.r2 = d2[RW] ? t2 : d2[RW-1:0];
      nx.q1 = {s_q[g-1].q1[NW-2:0], !d1[RW]};
      nx.q2 = {s_q[g-1].q2[NW-2:0], !d2[RW]};
    end
    always_ff @(posedge clk_i) begin
      if (adv[g] && v_q[g-1]) s_q[g] <= nx;
    end
  end

  function automatic logic [ls2_pkg::SolW-1:0] sat(input logic [NW-1:0] m, input logic neg);
    logic [NW:0] s;
    s = neg ? -{1'b0, m} : {1'b0, m};
    if (!neg && m > NW'({1'b0, {(ls2_pkg::SolW-1){1'b1}}}))
      return {1'b0, {(ls2_pkg::SolW-1){1'b1}}};
    if (neg && m > NW'({1'b1, {(ls2_pkg::SolW-1){1'b0}}}))
      return {1'b1, {(ls2_pkg::SolW-1){1'b0}}};
    return s[ls2_pkg::SolW-1:0];
  endfunction

  logic unq;
  assign unq      = s_q[NS].status == ls2_pkg::STAT_UNIQUE;
  assign valid_o  = v_q[NS];
  assign status_o = s_q[NS].status;
  assign sol1_o   = unq ? sat(s_q[NS].q1, s_q[NS].neg1) : '0;
  assign sol2_o   = unq ? sat(s_q[NS].q2, s_q[NS].neg2) : '0;

endmodule
`default_nettype wire
